// ===== src/diff_drive_odometry_pd_control_core_assert.svh =====
// Assertion macros for the odometry and drive core.
`ifndef DIFF_DRIVE_ODOMETRY_PD_CONTROL_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_PD_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DDO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddo assertion failed");

// Next-cycle implication, disabled in reset.
`define DDO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddo assertion failed");

`endif

// ===== src/ddo_pkg.sv =====
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int MUL_AW = 40;
  localparam int MUL_BW = 36;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW);
  localparam int COR_W  = 36;
  localparam int COR_IW = 5;

  typedef logic signed [MUL_AW-1:0] mul_a_t;
  typedef logic signed [MUL_BW-1:0] mul_b_t;
  typedef logic signed [MUL_PW-1:0] mul_p_t;
  typedef logic signed [COR_W-1:0]  cor_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam mul_b_t C_DS        = 36'sd46181528;
  localparam mul_b_t C_DH        = 36'sd1248149;
  localparam mul_b_t TENTH_TURN  = 36'sd17499271055;
  localparam mul_b_t HALF_PI_Q30 = 36'sd1686629713;
  localparam mul_b_t GAIN_Q30    = 36'sd652032874;

  localparam mul_p_t SAT_MAX = 76'sd2147483647;
  localparam mul_p_t SAT_MIN = -76'sd2147483648;

  typedef enum logic [2:0] {
    CFG_KP_DL = 3'd0,
    CFG_KD_DL = 3'd1,
    CFG_KP_DR = 3'd2,
    CFG_KD_DR = 3'd3,
    CFG_KP_HL = 3'd4,
    CFG_KP_HR = 3'd5,
    CFG_DSCL  = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DS, ST_DH, ST_V, ST_V10, ST_ABS, ST_N, ST_PH, ST_ZR, ST_ROT,
    ST_PX, ST_PY, ST_VEC, ST_RG, ST_ERR, ST_DD, ST_DV, ST_KPL, ST_KDL, ST_KHL,
    ST_KPR, ST_KDR, ST_KHR, ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input mul_p_t v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic cor_t atan_q30(input logic [COR_IW-1:0] i);
    case (i)
      5'd0:  return 36'sd843314857;
      5'd1:  return 36'sd497837829;
      5'd2:  return 36'sd263043837;
      5'd3:  return 36'sd133525159;
      5'd4:  return 36'sd67021687;
      5'd5:  return 36'sd33543516;
      5'd6:  return 36'sd16775851;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194283;
      5'd9:  return 36'sd2097149;
      5'd10: return 36'sd1048576;
      5'd11: return 36'sd524288;
      5'd12: return 36'sd262144;
      5'd13: return 36'sd131072;
      5'd14: return 36'sd65536;
      5'd15: return 36'sd32768;
      5'd16: return 36'sd16384;
      5'd17: return 36'sd8192;
      5'd18: return 36'sd4096;
      5'd19: return 36'sd2048;
      5'd20: return 36'sd1024;
      5'd21: return 36'sd512;
      5'd22: return 36'sd256;
      5'd23: return 36'sd128;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== src/ddo_mul.sv =====
`timescale 1ns / 1ps
module ddo_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ddo_pkg::mul_a_t     a,
  input  ddo_pkg::mul_b_t     b,
  output ddo_pkg::mul_p_t     p,
  output ddo_pkg::unit_stat_t st
);

  ddo_pkg::mul_p_t              a_r, a_nxt, acc_r, acc_nxt;
  ddo_pkg::mul_b_t              b_r, b_nxt;
  logic [ddo_pkg::MUL_CW-1:0]   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt, done_r, done_nxt;
  logic                         last;

  assign last = (cnt_r == ddo_pkg::MUL_CW'(ddo_pkg::MUL_BW - 1));

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = ddo_pkg::MUL_PW'(a);
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // sign bit of the multiplier carries negative weight
      if (b_r[0]) begin
        acc_nxt = last ? acc_r - a_r : acc_r + a_r;
      end
      a_nxt   = a_r <<< 1;
      b_nxt   = b_r >>> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign p       = acc_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

// ===== src/ddo_cordic.sv =====
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                vec,
  input  ddo_pkg::cor_t       x0,
  input  ddo_pkg::cor_t       y0,
  input  ddo_pkg::cor_t       z0,
  output ddo_pkg::cor_t       x,
  output ddo_pkg::cor_t       y,
  output ddo_pkg::unit_stat_t st
);

  ddo_pkg::cor_t              x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, xs, ys, at;
  logic [ddo_pkg::COR_IW-1:0] i_r, i_nxt;
  logic                       vec_r, vec_nxt, busy_r, busy_nxt, done_r, done_nxt, up;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = ddo_pkg::atan_q30(i_r);
  assign up = vec_r ? y_r[ddo_pkg::COR_W-1] : !z_r[ddo_pkg::COR_W-1];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    vec_nxt  = vec_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
      i_nxt    = '0;
      vec_nxt  = vec;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (up) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ddo_pkg::COR_IW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    vec_r <= vec_nxt;
  end

  assign x       = x_r;
  assign y       = y_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

// ===== src/diff_drive_odometry_pd_control_core.sv =====
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid / in_stall  enc_left, enc_right, target_distance, target_heading
// out      out_valid / out_stall drive_left/right, range, pos_x, pos_y, heading
// cfg      cfg_valid / cfg_ready cfg_index (3 bits), cfg_data (32 bits)
//
// Each tick runs through the one bit-serial 40x36 multiplier, shared by all fourteen
// products, and the one-step-per-cycle CORDIC unit used for sin/cos and for the range.
// rst_n is synchronous; it clears state, gains to their defaults and all handshakes.
// A result waiting under out_stall does not block the next transfer on in; the
// following result waits in the last step until the output register is free.
`include "diff_drive_odometry_pd_control_core_assert.svh"
module diff_drive_odometry_pd_control_core #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_enc_left,
  input  logic signed [31:0] in_enc_right,
  input  logic signed [31:0] in_target_distance,
  input  logic signed [31:0] in_target_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_left,
  output logic signed [31:0] out_drive_right,
  output logic        [30:0] out_range_from_origin,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic signed [31:0] out_heading_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int SH = 32 - FRAC_BITS;
  localparam ddo_pkg::mul_p_t RND_SH = 76'sd1 <<< (SH - 1);
  localparam ddo_pkg::mul_p_t RND_30 = 76'sd1 <<< 29;
  localparam logic signed [37:0] W_HALF = 38'sd1 <<< FRAC_BITS;

  ddo_pkg::state_t     state_r, state_nxt;
  logic                lch_r, lch_nxt;
  logic signed [31:0]  last_l_r, last_l_nxt, last_rt_r, last_rt_nxt;
  logic signed [31:0]  hs_r, hs_nxt, px_r, px_nxt, py_r, py_nxt, lerr_r, lerr_nxt;
  logic signed [31:0]  kpl_r, kpl_nxt, kdl_r, kdl_nxt, kpr_r, kpr_nxt, kdr_r, kdr_nxt;
  logic signed [31:0]  khl_r, khl_nxt, khr_r, khr_nxt;
  logic        [15:0]  dsc_r, dsc_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic signed [31:0]  dl_r, dl_nxt, dr_r, dr_nxt, tdist_r, tdist_nxt, thead_r, thead_nxt;
  logic signed [31:0]  ds_r, ds_nxt, dh_r, dh_nxt, zr_r, zr_nxt, c_r, c_nxt, s_r, s_nxt;
  logic signed [37:0]  w_r, w_nxt, nm;
  logic                neg_r, neg_nxt;
  ddo_pkg::mul_a_t     n_r, n_nxt;
  logic        [31:0]  phase_r, phase_nxt;
  ddo_pkg::cor_t       xm_r, xm_nxt;
  logic        [30:0]  range_r, range_nxt;
  logic signed [31:0]  err_r, err_nxt, herr_r, herr_nxt, deriv_r, deriv_nxt;
  logic signed [32:0]  dd_r, dd_nxt, dsum, ddif;
  ddo_pkg::mul_p_t     acc_r, acc_nxt, p_rsh, p_r30, p_f;
  logic signed [31:0]  left_r, left_nxt, right_r, right_nxt;
  logic signed [31:0]  o_dl_r, o_dl_nxt, o_dr_r, o_dr_nxt, o_px_r, o_px_nxt;
  logic signed [31:0]  o_py_r, o_py_nxt, o_hs_r, o_hs_nxt;
  logic        [30:0]  o_rg_r, o_rg_nxt;

  logic                mul_start, cor_start, cor_vec, use_mul, use_cor, mul_fin, cor_fin;
  ddo_pkg::mul_a_t     mul_a;
  ddo_pkg::mul_b_t     mul_b;
  ddo_pkg::mul_p_t     mul_p;
  ddo_pkg::unit_stat_t mul_st, cor_st;
  ddo_pkg::cor_t       cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_nx, cor_ny;

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .st    (mul_st)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .vec   (cor_vec),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .x     (cor_x),
    .y     (cor_y),
    .st    (cor_st)
  );

  assign dsum    = 33'(dl_r) + 33'(dr_r);
  assign ddif    = 33'(dr_r) - 33'(dl_r);
  assign p_rsh   = (mul_p + RND_SH) >>> SH;
  assign p_r30   = (mul_p + RND_30) >>> 30;
  assign p_f     = mul_p >>> FRAC_BITS;
  assign nm      = (w_r + W_HALF) >>> (FRAC_BITS + 1);
  assign cor_nx  = -cor_x;
  assign cor_ny  = -cor_y;
  assign mul_fin = lch_r & mul_st.done;
  assign cor_fin = lch_r & cor_st.done;

  assign in_stall  = (state_r != ddo_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive_left        = o_dl_r;
  assign out_drive_right       = o_dr_r;
  assign out_range_from_origin = o_rg_r;
  assign out_pos_x_out         = o_px_r;
  assign out_pos_y_out         = o_py_r;
  assign out_heading_out       = o_hs_r;

  always_comb begin
    kpl_nxt = kpl_r;
    kdl_nxt = kdl_r;
    kpr_nxt = kpr_r;
    kdr_nxt = kdr_r;
    khl_nxt = khl_r;
    khr_nxt = khr_r;
    dsc_nxt = dsc_r;
    if (cfg_valid) begin
      case (ddo_pkg::cfg_idx_t'(cfg_index))
        ddo_pkg::CFG_KP_DL: kpl_nxt = cfg_data;
        ddo_pkg::CFG_KD_DL: kdl_nxt = cfg_data;
        ddo_pkg::CFG_KP_DR: kpr_nxt = cfg_data;
        ddo_pkg::CFG_KD_DR: kdr_nxt = cfg_data;
        ddo_pkg::CFG_KP_HL: khl_nxt = cfg_data;
        ddo_pkg::CFG_KP_HR: khr_nxt = cfg_data;
        ddo_pkg::CFG_DSCL:  dsc_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lch_nxt       = lch_r;
    last_l_nxt    = last_l_r;
    last_rt_nxt   = last_rt_r;
    hs_nxt        = hs_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    lerr_nxt      = lerr_r;
    out_valid_nxt = out_valid_r & out_stall;
    dl_nxt        = dl_r;
    dr_nxt        = dr_r;
    tdist_nxt     = tdist_r;
    thead_nxt     = thead_r;
    ds_nxt        = ds_r;
    dh_nxt        = dh_r;
    w_nxt         = w_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    phase_nxt     = phase_r;
    zr_nxt        = zr_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    xm_nxt        = xm_r;
    range_nxt     = range_r;
    err_nxt       = err_r;
    herr_nxt      = herr_r;
    dd_nxt        = dd_r;
    deriv_nxt     = deriv_r;
    acc_nxt       = acc_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    o_dl_nxt      = o_dl_r;
    o_dr_nxt      = o_dr_r;
    o_rg_nxt      = o_rg_r;
    o_px_nxt      = o_px_r;
    o_py_nxt      = o_py_r;
    o_hs_nxt      = o_hs_r;
    use_mul       = 1'b0;
    use_cor       = 1'b0;
    mul_start     = 1'b0;
    cor_start     = 1'b0;
    cor_vec       = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    cor_x0        = '0;
    cor_y0        = '0;
    cor_z0        = '0;
    case (state_r)
      ddo_pkg::ST_IDLE: begin
        if (in_valid) begin
          dl_nxt      = in_enc_left - last_l_r;
          dr_nxt      = in_enc_right - last_rt_r;
          last_l_nxt  = in_enc_left;
          last_rt_nxt = in_enc_right;
          tdist_nxt   = in_target_distance;
          thead_nxt   = in_target_heading;
          state_nxt   = ddo_pkg::ST_DS;
        end
      end
      ddo_pkg::ST_DS: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(dsum);
        mul_b   = ddo_pkg::C_DS;
        if (mul_fin) begin
          ds_nxt    = ddo_pkg::sat32(p_rsh);
          state_nxt = ddo_pkg::ST_DH;
        end
      end
      ddo_pkg::ST_DH: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(ddif);
        mul_b   = ddo_pkg::C_DH;
        if (mul_fin) begin
          dh_nxt    = ddo_pkg::sat32(p_rsh);
          state_nxt = ddo_pkg::ST_V;
        end
      end
      ddo_pkg::ST_V: begin
        hs_nxt    = ddo_pkg::sat32(ddo_pkg::MUL_PW'(hs_r) + ddo_pkg::MUL_PW'(dh_r));
        w_nxt     = (38'(hs_r) <<< 1) + 38'(dh_r);
        state_nxt = ddo_pkg::ST_V10;
      end
      ddo_pkg::ST_V10: begin
        w_nxt     = (w_r <<< 3) + (w_r <<< 1);
        state_nxt = ddo_pkg::ST_ABS;
      end
      ddo_pkg::ST_ABS: begin
        neg_nxt   = w_r[37];
        w_nxt     = w_r[37] ? -w_r : w_r;
        state_nxt = ddo_pkg::ST_N;
      end
      ddo_pkg::ST_N: begin
        n_nxt     = neg_r ? -ddo_pkg::MUL_AW'(nm) : ddo_pkg::MUL_AW'(nm);
        state_nxt = ddo_pkg::ST_PH;
      end
      ddo_pkg::ST_PH: begin
        use_mul = 1'b1;
        mul_a   = n_r;
        mul_b   = ddo_pkg::TENTH_TURN;
        if (mul_fin) begin
          phase_nxt = mul_p[39:8];
          state_nxt = ddo_pkg::ST_ZR;
        end
      end
      ddo_pkg::ST_ZR: begin
        use_mul = 1'b1;
        mul_a   = {10'b0, phase_r[29:0]};
        mul_b   = ddo_pkg::HALF_PI_Q30;
        if (mul_fin) begin
          zr_nxt    = mul_p[61:30];
          state_nxt = ddo_pkg::ST_ROT;
        end
      end
      ddo_pkg::ST_ROT: begin
        use_cor = 1'b1;
        cor_x0  = ddo_pkg::GAIN_Q30;
        cor_z0  = ddo_pkg::COR_W'(zr_r);
        if (cor_fin) begin
          case (phase_r[31:30])
            2'd0: begin
              c_nxt = cor_x[31:0];
              s_nxt = cor_y[31:0];
            end
            2'd1: begin
              c_nxt = cor_ny[31:0];
              s_nxt = cor_x[31:0];
            end
            2'd2: begin
              c_nxt = cor_nx[31:0];
              s_nxt = cor_ny[31:0];
            end
            default: begin
              c_nxt = cor_y[31:0];
              s_nxt = cor_nx[31:0];
            end
          endcase
          state_nxt = ddo_pkg::ST_PX;
        end
      end
      ddo_pkg::ST_PX: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(ds_r);
        mul_b   = ddo_pkg::MUL_BW'(c_r);
        if (mul_fin) begin
          px_nxt    = ddo_pkg::sat32(ddo_pkg::MUL_PW'(px_r) + p_r30);
          state_nxt = ddo_pkg::ST_PY;
        end
      end
      ddo_pkg::ST_PY: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(ds_r);
        mul_b   = ddo_pkg::MUL_BW'(s_r);
        if (mul_fin) begin
          py_nxt    = ddo_pkg::sat32(ddo_pkg::MUL_PW'(py_r) + p_r30);
          state_nxt = ddo_pkg::ST_VEC;
        end
      end
      ddo_pkg::ST_VEC: begin
        use_cor = 1'b1;
        cor_vec = 1'b1;
        cor_x0  = px_r[31] ? -ddo_pkg::COR_W'(px_r) : ddo_pkg::COR_W'(px_r);
        cor_y0  = ddo_pkg::COR_W'(py_r);
        if (cor_fin) begin
          xm_nxt    = cor_x;
          state_nxt = ddo_pkg::ST_RG;
        end
      end
      ddo_pkg::ST_RG: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(xm_r);
        mul_b   = ddo_pkg::GAIN_Q30;
        if (mul_fin) begin
          if (p_r30 < 0) begin
            range_nxt = '0;
          end else if (p_r30 > ddo_pkg::SAT_MAX) begin
            range_nxt = 31'h7fffffff;
          end else begin
            range_nxt = p_r30[30:0];
          end
          state_nxt = ddo_pkg::ST_ERR;
        end
      end
      ddo_pkg::ST_ERR: begin
        err_nxt   = ddo_pkg::sat32(ddo_pkg::MUL_PW'(tdist_r)
                                   - ddo_pkg::MUL_PW'($signed({1'b0, range_r})));
        herr_nxt  = ddo_pkg::sat32(ddo_pkg::MUL_PW'(thead_r) - ddo_pkg::MUL_PW'(hs_r));
        state_nxt = ddo_pkg::ST_DD;
      end
      ddo_pkg::ST_DD: begin
        dd_nxt    = 33'(err_r) - 33'(lerr_r);
        lerr_nxt  = err_r;
        state_nxt = ddo_pkg::ST_DV;
      end
      ddo_pkg::ST_DV: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(dd_r);
        mul_b   = ddo_pkg::MUL_BW'($signed({1'b0, dsc_r}));
        if (mul_fin) begin
          deriv_nxt = ddo_pkg::sat32(mul_p);
          state_nxt = ddo_pkg::ST_KPL;
        end
      end
      ddo_pkg::ST_KPL: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(err_r);
        mul_b   = ddo_pkg::MUL_BW'(kpl_r);
        if (mul_fin) begin
          acc_nxt   = p_f;
          state_nxt = ddo_pkg::ST_KDL;
        end
      end
      ddo_pkg::ST_KDL: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(deriv_r);
        mul_b   = ddo_pkg::MUL_BW'(kdl_r);
        if (mul_fin) begin
          acc_nxt   = acc_r + p_f;
          state_nxt = ddo_pkg::ST_KHL;
        end
      end
      ddo_pkg::ST_KHL: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(herr_r);
        mul_b   = ddo_pkg::MUL_BW'(khl_r);
        if (mul_fin) begin
          left_nxt  = ddo_pkg::sat32(acc_r + p_f);
          state_nxt = ddo_pkg::ST_KPR;
        end
      end
      ddo_pkg::ST_KPR: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(err_r);
        mul_b   = ddo_pkg::MUL_BW'(kpr_r);
        if (mul_fin) begin
          acc_nxt   = p_f;
          state_nxt = ddo_pkg::ST_KDR;
        end
      end
      ddo_pkg::ST_KDR: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(deriv_r);
        mul_b   = ddo_pkg::MUL_BW'(kdr_r);
        if (mul_fin) begin
          acc_nxt   = acc_r + p_f;
          state_nxt = ddo_pkg::ST_KHR;
        end
      end
      ddo_pkg::ST_KHR: begin
        use_mul = 1'b1;
        mul_a   = ddo_pkg::MUL_AW'(herr_r);
        mul_b   = ddo_pkg::MUL_BW'(khr_r);
        if (mul_fin) begin
          right_nxt = ddo_pkg::sat32(acc_r + p_f);
          state_nxt = ddo_pkg::ST_OUT;
        end
      end
      ddo_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          o_dl_nxt      = left_r;
          o_dr_nxt      = right_r;
          o_rg_nxt      = range_r;
          o_px_nxt      = px_r;
          o_py_nxt      = py_r;
          o_hs_nxt      = hs_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ddo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ddo_pkg::ST_IDLE;
    endcase
    // launch the shared unit once per step, release it on completion
    if (mul_fin || cor_fin) begin
      lch_nxt = 1'b0;
    end else if ((use_mul || use_cor) && !lch_r) begin
      mul_start = use_mul;
      cor_start = use_cor;
      lch_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddo_pkg::ST_IDLE;
      lch_r       <= 1'b0;
      out_valid_r <= 1'b0;
      last_l_r    <= '0;
      last_rt_r   <= '0;
      hs_r        <= '0;
      px_r        <= '0;
      py_r        <= '0;
      lerr_r      <= '0;
      kpl_r       <= 32'sd524288;
      kdl_r       <= 32'sd6554;
      kpr_r       <= 32'sd327680;
      kdr_r       <= 32'sd26214;
      khl_r       <= 32'sd6554;
      khr_r       <= 32'sd6554;
      dsc_r       <= 16'd100;
    end else begin
      state_r     <= state_nxt;
      lch_r       <= lch_nxt;
      out_valid_r <= out_valid_nxt;
      last_l_r    <= last_l_nxt;
      last_rt_r   <= last_rt_nxt;
      hs_r        <= hs_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      lerr_r      <= lerr_nxt;
      kpl_r       <= kpl_nxt;
      kdl_r       <= kdl_nxt;
      kpr_r       <= kpr_nxt;
      kdr_r       <= kdr_nxt;
      khl_r       <= khl_nxt;
      khr_r       <= khr_nxt;
      dsc_r       <= dsc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r    <= dl_nxt;
    dr_r    <= dr_nxt;
    tdist_r <= tdist_nxt;
    thead_r <= thead_nxt;
    ds_r    <= ds_nxt;
    dh_r    <= dh_nxt;
    w_r     <= w_nxt;
    neg_r   <= neg_nxt;
    n_r     <= n_nxt;
    phase_r <= phase_nxt;
    zr_r    <= zr_nxt;
    c_r     <= c_nxt;
    s_r     <= s_nxt;
    xm_r    <= xm_nxt;
    range_r <= range_nxt;
    err_r   <= err_nxt;
    herr_r  <= herr_nxt;
    dd_r    <= dd_nxt;
    deriv_r <= deriv_nxt;
    acc_r   <= acc_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    o_dl_r  <= o_dl_nxt;
    o_dr_r  <= o_dr_nxt;
    o_rg_r  <= o_rg_nxt;
    o_px_r  <= o_px_nxt;
    o_py_r  <= o_py_nxt;
    o_hs_r  <= o_hs_nxt;
  end

  `DDO_ASSERT_NXT(a_take_blocks, in_valid && !in_stall, in_stall)
  `DDO_ASSERT_IMP(a_units_excl, mul_st.busy, !cor_st.busy)
  `DDO_ASSERT_IMP(a_idle_quiet, state_r == ddo_pkg::ST_IDLE, !mul_st.busy && !cor_st.busy)

endmodule
